/* rtl/core/decaying_reservoir_sampler_defines.svh */
// ----------------------------------------------------------------------------
// Decaying reservoir sampler assertion macros
// Shared property templates for the sampler's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DECAYING_RESERVOIR_SAMPLER_DEFINES_SVH
`define DECAYING_RESERVOIR_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* rtl/core/drs_pkg.sv */
// ----------------------------------------------------------------------------
// Decaying reservoir sampler package
// Sizes, codes, state encoding and reset values shared by the sampler files.
// ----------------------------------------------------------------------------
`default_nettype none

package drs_pkg;

   // Store geometry
   localparam int SLOTS  = 1024;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);

   // Field widths
   localparam int VALUE_W   = 64;
   localparam int TIME_W    = 48;
   localparam int DRAW_W    = 24;
   localparam int INDEX_W   = 10;
   localparam int WEIGHT_W  = 64;
   localparam int ENTRY_W   = 11;
   localparam int RATE_W    = 24;
   localparam int LIMIT_W   = 11;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 24;
   localparam int MUL_B_W   = 32;
   localparam int MUL_P_W   = RATE_W + MUL_B_W;
   localparam int FRAC_W    = 16;

   typedef logic [SLOT_W-1:0]    slot_type;
   typedef logic [CNT_W-1:0]     count_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // Register indexes
   localparam csr_idx_type CSR_DECAY_RATE = 1'd0;
   localparam csr_idx_type CSR_RES_LIMIT  = 1'd1;

   // Reset values: alpha 983 is about 0.015 per second in Q8.16
   localparam logic [RATE_W-1:0]  DECAY_RESET = 24'd983;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   typedef enum logic [0:0] {
      OP_OFFER = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      OUT_DROPPED   = 3'd0,
      OUT_INSERTED  = 3'd1,
      OUT_REPLACED  = 3'd2,
      OUT_BELOW     = 3'd3,
      OUT_DUPLICATE = 3'd4
   } outcome_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_HI,
      ST_MUL_LO,
      ST_SUM,
      ST_NEGATE,
      ST_KEY,
      ST_SCAN,
      ST_DECIDE,
      ST_READ,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/drs_if.sv */
// ----------------------------------------------------------------------------
// Decaying reservoir sampler channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface drs_req_if;
   logic                                valid;
   logic                                ready;
   logic                                opcode;
   logic [drs_pkg::VALUE_W-1:0]         sample_value;
   logic signed [drs_pkg::TIME_W-1:0]   elapsed_time;
   logic [drs_pkg::DRAW_W-1:0]          neg_log_draw;
   logic                                draw_is_zero;
   logic [drs_pkg::INDEX_W-1:0]         slot_index;

   modport source (output valid, opcode, sample_value, elapsed_time, neg_log_draw,
                   draw_is_zero, slot_index, input ready);
   modport sink (input valid, opcode, sample_value, elapsed_time, neg_log_draw,
                 draw_is_zero, slot_index, output ready);
endinterface

interface drs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [2:0]                          offer_outcome;
   logic                                read_valid;
   logic [drs_pkg::VALUE_W-1:0]         read_value;
   logic signed [drs_pkg::WEIGHT_W-1:0] read_log_weight;
   logic [drs_pkg::ENTRY_W-1:0]         entry_count;

   modport source (output valid, offer_outcome, read_valid, read_value,
                   read_log_weight, entry_count, input ready);
   modport sink (input valid, offer_outcome, read_valid, read_value,
                 read_log_weight, entry_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/decaying_reservoir_sampler.sv */
// ----------------------------------------------------------------------------
// Decaying reservoir sampler
// Forward-decay weighted reservoir in the log domain, Q.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req_port (valid/ready) carries one beat per op: an offer (opcode 0) with
//   value, elapsed time and -ln(u), or a read (opcode 1) of one slot.
//   rsp_port (valid/ready) returns exactly one beat per request beat with the
//   outcome, the read slot contents and the number of samples held.
//   csr_wr_en/csr_index/csr_wdata write decay_rate (0) and reservoir_limit (1);
//   write them only while no request is in flight.
// Sequencing:
//   An offer goes from request beat to response beat through the shared
//   24x32 multiplier and adders for weight and key (multiply high/low, sum,
//   negate, key), one key-memory read per held sample (single read port),
//   a fold of the last read, then the update. A read does a data-memory
//   read instead and a zero-draw offer neither. req_port.ready is high
//   only while idle, so the next request beat can come at the response beat.
// Reset clears the held count (slot occupancy follows from it, so the memories
//   need no clearing pass) and loads the register reset values.
// A stalled receiver holds the response beat in the output register; the next
//   request is still taken and parks when done until that register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decaying_reservoir_sampler_defines.svh"

module decaying_reservoir_sampler (
   input  wire logic                              clock,
   input  wire logic                              reset,
   drs_req_if.sink                                req_port,
   drs_rsp_if.source                              rsp_port,
   input  wire logic                              csr_wr_en,
   input  wire logic [drs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [drs_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   // Control registers
   drs_pkg::state_type  state_ff, state_in;
   drs_pkg::count_type  held_count_ff, held_count_in;
   drs_pkg::count_type  scan_cnt_ff, scan_cnt_in;
   logic [drs_pkg::RATE_W-1:0]  decay_rate_ff, decay_rate_in;
   logic [drs_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic pend_ff, pend_in;
   logic dup_ff, dup_in;
   logic have_min_ff, have_min_in;

   // Datapath registers
   logic                                neg_ff, neg_in;
   logic [drs_pkg::TIME_W-1:0]          mag_ff, mag_in;
   logic [drs_pkg::VALUE_W-1:0]         value_ff, value_in;
   logic [drs_pkg::DRAW_W-1:0]          draw_ff, draw_in;
   logic [drs_pkg::MUL_P_W-1:0]         hi_ff, hi_in;
   logic [drs_pkg::RATE_W+drs_pkg::FRAC_W-1:0] lo_ff, lo_in;
   logic [drs_pkg::WEIGHT_W-1:0]        q_ff, q_in;
   logic signed [drs_pkg::WEIGHT_W-1:0] w_ff, w_in;
   logic signed [drs_pkg::WEIGHT_W-1:0] key_ff, key_in;
   logic signed [drs_pkg::WEIGHT_W-1:0] min_key_ff, min_key_in;
   drs_pkg::slot_type                   min_slot_ff, min_slot_in;
   drs_pkg::slot_type                   pend_idx_ff, pend_idx_in;
   drs_pkg::outcome_type                res_outcome_ff, res_outcome_in;
   logic                                res_rvalid_ff, res_rvalid_in;
   logic [drs_pkg::VALUE_W-1:0]         res_rvalue_ff, res_rvalue_in;
   logic signed [drs_pkg::WEIGHT_W-1:0] res_rweight_ff, res_rweight_in;
   drs_pkg::outcome_type                out_outcome_ff, out_outcome_in;
   logic                                out_rvalid_ff, out_rvalid_in;
   logic [drs_pkg::VALUE_W-1:0]         out_rvalue_ff, out_rvalue_in;
   logic signed [drs_pkg::WEIGHT_W-1:0] out_rweight_ff, out_rweight_in;
   logic [drs_pkg::ENTRY_W-1:0]         out_count_ff, out_count_in;

   // Shared multiplier
   logic [drs_pkg::MUL_B_W-1:0] mul_b;
   logic [drs_pkg::MUL_P_W-1:0] mul_prod;

   // Memory ports
   logic                                      key_wr_en, key_rd_en;
   drs_pkg::slot_type                         key_wr_addr, key_rd_addr;
   logic [drs_pkg::WEIGHT_W-1:0]              key_rdata;
   logic                                      data_wr_en, data_rd_en;
   drs_pkg::slot_type                         data_wr_addr, data_rd_addr;
   logic [drs_pkg::VALUE_W+drs_pkg::WEIGHT_W-1:0] data_wdata, data_rdata;
   drs_pkg::slot_type                         upd_slot;

   // Helpers
   logic [drs_pkg::CNT_W+drs_pkg::LIMIT_W-1:0]  lim_wide;
   drs_pkg::count_type                          lim_eff;
   logic [drs_pkg::SLOT_W+drs_pkg::INDEX_W-1:0] idx_wide;
   logic                                        read_hit;
   logic [drs_pkg::ENTRY_W+drs_pkg::CNT_W-1:0]  count_wide;
   logic signed [drs_pkg::WEIGHT_W-1:0]         scan_key;
   logic                                        load_rsp;

   drs_ram #(
      .WIDTH (drs_pkg::WEIGHT_W),
      .DEPTH (drs_pkg::SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_ff),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (key_rdata)
   );

   drs_ram #(
      .WIDTH (drs_pkg::VALUE_W + drs_pkg::WEIGHT_W),
      .DEPTH (drs_pkg::SLOTS)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (data_wr_addr),
      .wr_data (data_wdata),
      .rd_en   (data_rd_en),
      .rd_addr (data_rd_addr),
      .rd_data (data_rdata)
   );

   // Clamp the limit to 1..SLOTS
   assign lim_wide = {{drs_pkg::CNT_W{1'b0}}, limit_ff};
   always_comb begin
      if (limit_ff == '0) begin
         lim_eff = drs_pkg::count_type'(1);
      end else if (lim_wide > drs_pkg::SLOTS) begin
         lim_eff = drs_pkg::count_type'(drs_pkg::SLOTS);
      end else begin
         lim_eff = lim_wide[drs_pkg::CNT_W-1:0];
      end
   end

   // Slots fill from zero and never free, so slot i is used iff i < held count
   assign idx_wide = {{drs_pkg::SLOT_W{1'b0}}, req_port.slot_index};
   assign read_hit = (idx_wide < drs_pkg::SLOTS) && (idx_wide < held_count_ff);

   assign count_wide = {{drs_pkg::ENTRY_W{1'b0}}, held_count_ff};
   assign scan_key   = $signed(key_rdata);

   // Share one multiplier between the high and low halves of the magnitude
   assign mul_b    = (state_ff == drs_pkg::ST_MUL_HI) ?
                     mag_ff[drs_pkg::TIME_W-1:drs_pkg::FRAC_W] :
                     {{(drs_pkg::MUL_B_W-drs_pkg::FRAC_W){1'b0}},
                      mag_ff[drs_pkg::FRAC_W-1:0]};
   assign mul_prod = {{drs_pkg::MUL_B_W{1'b0}}, decay_rate_ff} *
                     {{drs_pkg::RATE_W{1'b0}}, mul_b};

   assign key_rd_addr  = scan_cnt_ff[drs_pkg::SLOT_W-1:0];
   assign key_wr_addr  = upd_slot;
   assign data_wr_addr = upd_slot;
   assign data_rd_addr = idx_wide[drs_pkg::SLOT_W-1:0];
   assign data_wdata   = {value_ff, w_ff};

   always_comb begin
      state_in       = state_ff;
      held_count_in  = held_count_ff;
      scan_cnt_in    = scan_cnt_ff;
      decay_rate_in  = decay_rate_ff;
      limit_in       = limit_ff;
      pend_in        = 1'b0;
      dup_in         = dup_ff;
      have_min_in    = have_min_ff;
      neg_in         = neg_ff;
      mag_in         = mag_ff;
      value_in       = value_ff;
      draw_in        = draw_ff;
      hi_in          = hi_ff;
      lo_in          = lo_ff;
      q_in           = q_ff;
      w_in           = w_ff;
      key_in         = key_ff;
      min_key_in     = min_key_ff;
      min_slot_in    = min_slot_ff;
      pend_idx_in    = pend_idx_ff;
      res_outcome_in = res_outcome_ff;
      res_rvalid_in  = res_rvalid_ff;
      res_rvalue_in  = res_rvalue_ff;
      res_rweight_in = res_rweight_ff;
      out_outcome_in = out_outcome_ff;
      out_rvalid_in  = out_rvalid_ff;
      out_rvalue_in  = out_rvalue_ff;
      out_rweight_in = out_rweight_ff;
      out_count_in   = out_count_ff;
      key_rd_en      = 1'b0;
      key_wr_en      = 1'b0;
      data_rd_en     = 1'b0;
      data_wr_en     = 1'b0;
      upd_slot       = min_slot_ff;
      load_rsp       = 1'b0;
      req_port.ready = 1'b0;

      // Register writes
      if (csr_wr_en) begin
         case (csr_index)
            drs_pkg::CSR_DECAY_RATE: decay_rate_in = csr_wdata[drs_pkg::RATE_W-1:0];
            drs_pkg::CSR_RES_LIMIT:  limit_in      = csr_wdata[drs_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end

      // Fold in the key read issued last cycle
      if (pend_ff) begin
         if (scan_key == key_ff) begin
            dup_in = 1'b1;
         end
         if (!have_min_ff || (scan_key < min_key_ff)) begin
            min_key_in  = scan_key;
            min_slot_in = pend_idx_ff;
            have_min_in = 1'b1;
         end
      end

      case (state_ff)
         drs_pkg::ST_IDLE: begin
            req_port.ready = 1'b1;
            if (req_port.valid) begin
               res_outcome_in = drs_pkg::OUT_DROPPED;
               res_rvalid_in  = 1'b0;
               res_rvalue_in  = '0;
               res_rweight_in = '0;
               value_in       = req_port.sample_value;
               draw_in        = req_port.neg_log_draw;
               neg_in         = req_port.elapsed_time[drs_pkg::TIME_W-1];
               mag_in         = req_port.elapsed_time[drs_pkg::TIME_W-1] ?
                                ('0 - req_port.elapsed_time) : req_port.elapsed_time;
               scan_cnt_in    = '0;
               dup_in         = 1'b0;
               have_min_in    = 1'b0;
               if (drs_pkg::op_type'(req_port.opcode) == drs_pkg::OP_READ) begin
                  res_rvalid_in = read_hit;
                  data_rd_en    = read_hit;
                  state_in      = drs_pkg::ST_READ;
               end else if (req_port.draw_is_zero) begin
                  state_in = drs_pkg::ST_DONE;
               end else begin
                  state_in = drs_pkg::ST_MUL_HI;
               end
            end
         end
         drs_pkg::ST_MUL_HI: begin
            hi_in    = mul_prod;
            state_in = drs_pkg::ST_MUL_LO;
         end
         drs_pkg::ST_MUL_LO: begin
            lo_in    = mul_prod[drs_pkg::RATE_W+drs_pkg::FRAC_W-1:0];
            state_in = drs_pkg::ST_SUM;
         end
         drs_pkg::ST_SUM: begin
            // Magnitude product over 2^16; round up for negative times
            q_in = {{(drs_pkg::WEIGHT_W-drs_pkg::MUL_P_W){1'b0}}, hi_ff} +
                   {{(drs_pkg::WEIGHT_W-drs_pkg::RATE_W){1'b0}},
                    lo_ff[drs_pkg::RATE_W+drs_pkg::FRAC_W-1:drs_pkg::FRAC_W]} +
                   {{(drs_pkg::WEIGHT_W-1){1'b0}},
                    (neg_ff && (lo_ff[drs_pkg::FRAC_W-1:0] != '0))};
            state_in = drs_pkg::ST_NEGATE;
         end
         drs_pkg::ST_NEGATE: begin
            w_in     = neg_ff ? -$signed(q_ff) : $signed(q_ff);
            state_in = drs_pkg::ST_KEY;
         end
         drs_pkg::ST_KEY: begin
            key_in   = w_ff + $signed({{(drs_pkg::WEIGHT_W-drs_pkg::DRAW_W){1'b0}}, draw_ff});
            state_in = drs_pkg::ST_SCAN;
         end
         drs_pkg::ST_SCAN: begin
            // Walk the used slots, one key read per cycle
            if (scan_cnt_ff != held_count_ff) begin
               key_rd_en   = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = scan_cnt_ff[drs_pkg::SLOT_W-1:0];
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = drs_pkg::ST_DECIDE;
            end
         end
         drs_pkg::ST_DECIDE: begin
            if (dup_ff) begin
               res_outcome_in = drs_pkg::OUT_DUPLICATE;
            end else if (held_count_ff < lim_eff) begin
               upd_slot       = held_count_ff[drs_pkg::SLOT_W-1:0];
               key_wr_en      = 1'b1;
               data_wr_en     = 1'b1;
               held_count_in  = held_count_ff + 1'b1;
               res_outcome_in = drs_pkg::OUT_INSERTED;
            end else if (have_min_ff && (key_ff > min_key_ff)) begin
               key_wr_en      = 1'b1;
               data_wr_en     = 1'b1;
               res_outcome_in = drs_pkg::OUT_REPLACED;
            end else begin
               res_outcome_in = drs_pkg::OUT_BELOW;
            end
            state_in = drs_pkg::ST_DONE;
         end
         drs_pkg::ST_READ: begin
            if (res_rvalid_ff) begin
               res_rvalue_in  = data_rdata[drs_pkg::VALUE_W+drs_pkg::WEIGHT_W-1:
                                           drs_pkg::WEIGHT_W];
               res_rweight_in = $signed(data_rdata[drs_pkg::WEIGHT_W-1:0]);
            end
            state_in = drs_pkg::ST_DONE;
         end
         drs_pkg::ST_DONE: begin
            // Park until the output register frees up
            if (!rsp_valid_ff || rsp_port.ready) begin
               load_rsp = 1'b1;
               state_in = drs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = drs_pkg::ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         out_outcome_in = res_outcome_ff;
         out_rvalid_in  = res_rvalid_ff;
         out_rvalue_in  = res_rvalue_ff;
         out_rweight_in = res_rweight_ff;
         out_count_in   = count_wide[drs_pkg::ENTRY_W-1:0];
      end
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_port.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= drs_pkg::ST_IDLE;
         held_count_ff <= '0;
         scan_cnt_ff   <= '0;
         decay_rate_ff <= drs_pkg::DECAY_RESET;
         limit_ff      <= drs_pkg::LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
         dup_ff        <= 1'b0;
         have_min_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_count_ff <= held_count_in;
         scan_cnt_ff   <= scan_cnt_in;
         decay_rate_ff <= decay_rate_in;
         limit_ff      <= limit_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_ff       <= pend_in;
         dup_ff        <= dup_in;
         have_min_ff   <= have_min_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff         <= neg_in;
      mag_ff         <= mag_in;
      value_ff       <= value_in;
      draw_ff        <= draw_in;
      hi_ff          <= hi_in;
      lo_ff          <= lo_in;
      q_ff           <= q_in;
      w_ff           <= w_in;
      key_ff         <= key_in;
      min_key_ff     <= min_key_in;
      min_slot_ff    <= min_slot_in;
      pend_idx_ff    <= pend_idx_in;
      res_outcome_ff <= res_outcome_in;
      res_rvalid_ff  <= res_rvalid_in;
      res_rvalue_ff  <= res_rvalue_in;
      res_rweight_ff <= res_rweight_in;
      out_outcome_ff <= out_outcome_in;
      out_rvalid_ff  <= out_rvalid_in;
      out_rvalue_ff  <= out_rvalue_in;
      out_rweight_ff <= out_rweight_in;
      out_count_ff   <= out_count_in;
   end

   // Drive the response channel from the output register
   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.offer_outcome   = out_outcome_ff;
   assign rsp_port.read_valid      = out_rvalid_ff;
   assign rsp_port.read_value      = out_rvalue_ff;
   assign rsp_port.read_log_weight = out_rweight_ff;
   assign rsp_port.entry_count     = out_count_ff;

   // Checks
   `DRS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, held_count_ff <= drs_pkg::SLOTS)
   `DRS_ASSERT_IMPL(a_scan_bound, clock, reset, state_ff == drs_pkg::ST_SCAN, scan_cnt_ff <= held_count_ff)
   `DRS_ASSERT_NEXT(a_insert_grows, clock, reset, (state_ff == drs_pkg::ST_DECIDE) && (res_outcome_in == drs_pkg::OUT_INSERTED), held_count_ff == drs_pkg::count_type'($past(held_count_ff) + 1'b1))
   `DRS_ASSERT_IMPL(a_replace_full, clock, reset, (state_ff == drs_pkg::ST_DECIDE) && (res_outcome_in == drs_pkg::OUT_REPLACED), held_count_ff >= lim_eff)

endmodule

`default_nettype wire

/* rtl/core/drs_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decaying reservoir sampler testbench
// Sends offer and slot-read beats through the request channel, keeps a mirror
// of the reservoir in a scoreboard and checks each response beat field by
// field. The run steps through several decay rate and limit settings.
// ----------------------------------------------------------------------------
module tb_top;
   import drs_pkg::*;

   // No beat in either direction for this many cycles ends the run. The
   // limit leaves a wide margin over the slowest offer, which scans every
   // held slot, and over the long receiver hold of LONG_HOLD_CYCLES.
   localparam int WATCHDOG_LIMIT   = 20000;
   localparam int LONG_HOLD_CYCLES = 2000;
   localparam int SETTLE_CYCLES    = 4;
   localparam int DRAIN_CYCLES     = 16;

   localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
   localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

   typedef struct {
      op_type                     opcode;
      logic [VALUE_W-1:0]         sample_value;
      logic signed [TIME_W-1:0]   elapsed_time;
      logic [DRAW_W-1:0]          neg_log_draw;
      logic                       draw_is_zero;
      logic [INDEX_W-1:0]         slot_index;
   } request_type;

   typedef struct {
      outcome_type                offer_outcome;
      logic                       read_valid;
      logic [VALUE_W-1:0]         read_value;
      logic signed [WEIGHT_W-1:0] read_log_weight;
      logic [ENTRY_W-1:0]         entry_count;
   } response_type;

   // -------------------------------------------------------------------------
   // Scoreboard: mirror of the reservoir plus the responses still owed
   // -------------------------------------------------------------------------
   class reservoir_mirror;
      logic signed [63:0]      slot_key [SLOTS];
      logic [VALUE_W-1:0]      slot_value [SLOTS];
      logic signed [63:0]      slot_weight [SLOTS];
      bit                      slot_used [SLOTS];
      int unsigned             held;
      logic [RATE_W-1:0]       rate;
      logic [LIMIT_W-1:0]      limit;
      response_type            awaited_results [$];
      int unsigned             failures;

      function new();
         held     = 0;
         rate     = DECAY_RESET;
         limit    = LIMIT_RESET;
         failures = 0;
         foreach (slot_used[i]) slot_used[i] = 1'b0;
      endfunction

      function void load_register(csr_idx_type idx, logic [CSR_DAT_W-1:0] data);
         if (idx == CSR_DECAY_RATE) rate = data[RATE_W-1:0];
         else if (idx == CSR_RES_LIMIT) limit = data[LIMIT_W-1:0];
      endfunction

      // floor(rate * t / 2^16), exact product, rounded toward minus infinity
      function logic signed [63:0] decayed_weight(logic signed [TIME_W-1:0] t);
         logic signed [RATE_W+TIME_W:0] product;
         product = $signed({1'b0, rate}) * t;
         return 64'(product >>> FRAC_W);
      endfunction

      function response_type apply_to_reservoir(request_type r);
         response_type       res;
         logic signed [63:0] weight;
         logic signed [63:0] key;
         int unsigned        cap;
         int                 free_slot;
         int                 min_slot;
         bit                 dup;
         res.offer_outcome   = OUT_DROPPED;
         res.read_valid      = 1'b0;
         res.read_value      = '0;
         res.read_log_weight = '0;
         if (r.opcode == OP_READ) begin
            if (slot_used[r.slot_index]) begin
               res.read_valid      = 1'b1;
               res.read_value      = slot_value[r.slot_index];
               res.read_log_weight = slot_weight[r.slot_index];
            end
         end else if (!r.draw_is_zero) begin
            weight = decayed_weight(r.elapsed_time);
            key    = weight + $signed({40'd0, r.neg_log_draw});
            // a limit of zero keeps one sample, anything above SLOTS keeps SLOTS
            cap = (limit == 0) ? 1 : (limit > SLOTS) ? SLOTS : limit;
            free_slot = -1;
            min_slot  = -1;
            dup       = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i]) begin
                  if (slot_key[i] == key) dup = 1'b1;
                  if (min_slot < 0 || slot_key[i] < slot_key[min_slot]) min_slot = i;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (dup) begin
               res.offer_outcome = OUT_DUPLICATE;
            end else if (held < cap && free_slot >= 0) begin
               slot_used[free_slot]   = 1'b1;
               slot_key[free_slot]    = key;
               slot_value[free_slot]  = r.sample_value;
               slot_weight[free_slot] = weight;
               held++;
               res.offer_outcome = OUT_INSERTED;
            end else if (min_slot >= 0 && key > slot_key[min_slot]) begin
               slot_key[min_slot]    = key;
               slot_value[min_slot]  = r.sample_value;
               slot_weight[min_slot] = weight;
               res.offer_outcome = OUT_REPLACED;
            end else begin
               res.offer_outcome = OUT_BELOW;
            end
         end
         res.entry_count = held[ENTRY_W-1:0];
         return res;
      endfunction

      function void note_request(request_type r);
         awaited_results.push_back(apply_to_reservoir(r));
      endfunction

      function int outstanding();
         return awaited_results.size();
      endfunction

      task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
         $display("%0t: %s mismatch, got %h, expected %h", $time, field, got, want);
         failures++;
      endtask

      task check_response(response_type got);
         response_type want;
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected response beat", got.entry_count, '0);
            return;
         end
         want = awaited_results.pop_front();
         if (got.offer_outcome !== want.offer_outcome)
            report_mismatch("offer_outcome", got.offer_outcome, want.offer_outcome);
         if (got.read_valid !== want.read_valid)
            report_mismatch("read_valid", got.read_valid, want.read_valid);
         if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
         if (got.read_log_weight !== want.read_log_weight)
            report_mismatch("read_log_weight", got.read_log_weight, want.read_log_weight);
         if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", got.entry_count, want.entry_count);
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   csr_idx_type          csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   drs_req_if req_bus ();
   drs_rsp_if rsp_bus ();

   decaying_reservoir_sampler dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   reservoir_mirror mirror;
   bit              receiver_idles;
   bit              hold_off_request;
   int unsigned     quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Response side: drive ready at the falling edge. Stall in short random
   // bursts while idling is on; on request, hold off for a long stretch so the
   // block parks a finished beat and stops taking requests.
   // -------------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_request) begin
            rsp_bus.ready = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         @(negedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge. Check the response
   // beat first so that a request taken at the same edge cannot satisfy it.
   // Count quiet cycles for the watchdog.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      request_type  seen;
      response_type got;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.offer_outcome   = outcome_type'(rsp_bus.offer_outcome);
            got.read_valid      = rsp_bus.read_valid;
            got.read_value      = rsp_bus.read_value;
            got.read_log_weight = rsp_bus.read_log_weight;
            got.entry_count     = rsp_bus.entry_count;
            mirror.check_response(got);
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.opcode       = op_type'(req_bus.opcode);
            seen.sample_value = req_bus.sample_value;
            seen.elapsed_time = req_bus.elapsed_time;
            seen.neg_log_draw = req_bus.neg_log_draw;
            seen.draw_is_zero = req_bus.draw_is_zero;
            seen.slot_index   = req_bus.slot_index;
            mirror.note_request(seen);
         end
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("decaying_reservoir_sampler test failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Present one beat at the falling edge, optionally after an idle burst, and
   // hold it until the block takes it. Return at the following falling edge.
   task automatic send_request(input request_type r, input bit idles);
      if (idles && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_bus.opcode       = r.opcode;
      req_bus.sample_value = r.sample_value;
      req_bus.elapsed_time = r.elapsed_time;
      req_bus.neg_log_draw = r.neg_log_draw;
      req_bus.draw_is_zero = r.draw_is_zero;
      req_bus.slot_index   = r.slot_index;
      req_bus.valid        = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed response beat has arrived.
   task automatic settle_block();
      req_bus.valid = 1'b0;
      while (mirror.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_register(input csr_idx_type idx, input logic [CSR_DAT_W-1:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      mirror.load_register(idx, data);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic request_type offer_of(logic [VALUE_W-1:0] value,
                                            logic signed [TIME_W-1:0] t,
                                            logic [DRAW_W-1:0] draw, logic zero);
      request_type r;
      r.opcode       = OP_OFFER;
      r.sample_value = value;
      r.elapsed_time = t;
      r.neg_log_draw = draw;
      r.draw_is_zero = zero;
      r.slot_index   = '0;
      return r;
   endfunction

   function automatic request_type read_of(logic [INDEX_W-1:0] idx);
      request_type r;
      r = offer_of('0, '0, '0, 1'b0);
      r.opcode     = OP_READ;
      r.slot_index = idx;
      return r;
   endfunction

   // Mostly offers. Small times and draws make keys collide so duplicates and
   // near-minimum keys show up; reads aim mostly at slots that are in use.
   function automatic request_type random_request();
      request_type  r;
      logic [63:0]  noise;
      int unsigned  reach;
      noise = {$urandom, $urandom};
      reach = (mirror.held + 2 > SLOTS - 1) ? SLOTS - 1 : mirror.held + 2;
      r.opcode       = ($urandom_range(0, 3) == 0) ? OP_READ : OP_OFFER;
      r.sample_value = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: r.elapsed_time = noise[TIME_W-1:0];
         1: r.elapsed_time = $signed(TIME_W'($urandom_range(0, 64))) - 48'sd32;
         2: r.elapsed_time = {{(TIME_W-32){noise[31]}}, noise[31:0]};
         default: begin
            case ($urandom_range(0, 3))
               0: r.elapsed_time = TIME_MAX;
               1: r.elapsed_time = TIME_MIN;
               2: r.elapsed_time = '1;
               default: r.elapsed_time = '0;
            endcase
         end
      endcase
      if ($urandom_range(0, 1) == 0) r.neg_log_draw = noise[63:64-DRAW_W];
      else r.neg_log_draw = DRAW_W'($urandom_range(0, 15));
      r.draw_is_zero = ($urandom_range(0, 15) == 0);
      if ($urandom_range(0, 9) < 7) r.slot_index = INDEX_W'($urandom_range(0, reach));
      else r.slot_index = INDEX_W'($urandom_range(0, SLOTS - 1));
      return r;
   endfunction

   // One setting of the registers followed by a run of random beats.
   task automatic run_phase(input logic [RATE_W-1:0] rate, input logic [LIMIT_W-1:0] limit,
                            input int count, input bit idles, input int pause_at,
                            input bit long_hold);
      settle_block();
      program_register(CSR_DECAY_RATE, rate);
      program_register(CSR_RES_LIMIT, {{(CSR_DAT_W-LIMIT_W){1'b0}}, limit});
      receiver_idles   = idles;
      hold_off_request = long_hold;
      for (int n = 0; n < count; n++) begin
         if (n == pause_at) settle_block();
         send_request(random_request(), idles);
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      mirror               = new();
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = CSR_DECAY_RATE;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = OP_OFFER;
      req_bus.sample_value = '0;
      req_bus.elapsed_time = '0;
      req_bus.neg_log_draw = '0;
      req_bus.draw_is_zero = 1'b0;
      req_bus.slot_index   = '0;
      receiver_idles       = 1'b1;
      hold_off_request     = 1'b0;
      quiet_cycles         = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset registers: empty reads, zero draw, extreme offers, duplicate key
      send_request(read_of('0), 1'b1);
      send_request(read_of('1), 1'b1);
      send_request(offer_of(64'h0123_4567_89ab_cdef, 48'sd5, 24'd7, 1'b1), 1'b1);
      send_request(offer_of('1, TIME_MAX, '1, 1'b0), 1'b1);
      send_request(offer_of('1, TIME_MAX, '1, 1'b0), 1'b1);
      send_request(offer_of('0, TIME_MIN, '0, 1'b0), 1'b1);
      send_request(read_of(10'd0), 1'b1);
      send_request(read_of(10'd1), 1'b1);

      // Zero rate and a zero limit: the store is over its limit, so offers with a
      // nonzero draw only replace the minimum, fall below it or hit a duplicate key
      settle_block();
      program_register(CSR_DECAY_RATE, '0);
      program_register(CSR_RES_LIMIT, '0);
      send_request(offer_of(64'hfeed_0000_0000_0001, -48'sd5, 24'd5, 1'b0), 1'b1);
      send_request(offer_of(64'hfeed_0000_0000_0002, 48'sd100, 24'd3, 1'b0), 1'b1);
      send_request(offer_of(64'hfeed_0000_0000_0003, 48'sd7, 24'd5, 1'b0), 1'b1);
      send_request(read_of(10'd1), 1'b1);
      send_request(offer_of(64'hfeed_0000_0000_0004, -48'sd9, 24'd0, 1'b0), 1'b1);
      send_request(offer_of(64'hfeed_0000_0000_0005, 48'sd0, 24'd0, 1'b1), 1'b1);

      // Fastest decay and an out-of-range limit: weights round toward minus
      // infinity on both sides of zero
      settle_block();
      program_register(CSR_DECAY_RATE, {RATE_W{1'b1}});
      program_register(CSR_RES_LIMIT, {{(CSR_DAT_W-LIMIT_W){1'b0}}, {LIMIT_W{1'b1}}});
      send_request(offer_of(64'h5555_aaaa_5555_aaaa, -48'sd1, 24'd1, 1'b0), 1'b1);
      send_request(offer_of(64'haaaa_5555_aaaa_5555, 48'sd1, 24'd1, 1'b0), 1'b1);
      send_request(offer_of(64'h8000_0000_0000_0000, TIME_MAX, '0, 1'b0), 1'b1);
      send_request(offer_of(64'h0000_0000_0000_0001, TIME_MIN, '1, 1'b0), 1'b1);
      for (int s = 2; s < 6; s++) send_request(read_of(INDEX_W'(s)), 1'b1);

      // Random phases: grow the store slowly so offers stay fast
      run_phase(DECAY_RESET, 11'd8, 110, 1'b1, -1, 1'b0);
      run_phase(RATE_W'($urandom_range(1, (1 << RATE_W) - 1)), 11'd1, 90, 1'b1, -1, 1'b1);
      run_phase(RATE_W'($urandom_range(1, (1 << RATE_W) - 1)), 11'd24, 110, 1'b1, 55, 1'b0);
      run_phase('0, 11'd16, 60, 1'b1, -1, 1'b0);
      run_phase(RATE_W'($urandom_range(1, (1 << RATE_W) - 1)), LIMIT_RESET, 90, 1'b1, -1,
                1'b0);
      // last part with no idling on either side
      run_phase(RATE_W'($urandom_range(1, (1 << RATE_W) - 1)), 11'd64, 120, 1'b0, -1, 1'b0);

      settle_block();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mirror.failures == 0)
         $display("decaying_reservoir_sampler test passed");
      else
         $display("decaying_reservoir_sampler test failed");
      $finish;
   end

endmodule
